// ----- design/grt_pkg.sv -----
// ----------------------------------------------------------------------------
// grt_pkg
// Types and constants shared by the gated RPM tachometer.
// ----------------------------------------------------------------------------
package grt_pkg;

    localparam int unsigned CfgIdxW  = 3;
    localparam int unsigned CfgDataW = 24;

    localparam logic [CfgIdxW-1:0] REG_LOCKOUT = 3'd0;
    localparam logic [CfgIdxW-1:0] REG_GATE    = 3'd1;
    localparam logic [CfgIdxW-1:0] REG_WFIRST  = 3'd2;
    localparam logic [CfgIdxW-1:0] REG_WLAST   = 3'd3;
    localparam logic [CfgIdxW-1:0] REG_TGATES  = 3'd4;
    localparam logic [CfgIdxW-1:0] REG_SCALE   = 3'd5;

    localparam logic [15:0] RST_LOCKOUT = 16'd5000;
    localparam logic [23:0] RST_GATE    = 24'd1000000;
    localparam logic [7:0]  RST_WFIRST  = 8'd3;
    localparam logic [7:0]  RST_WLAST   = 8'd8;
    localparam logic [7:0]  RST_TGATES  = 8'd10;
    localparam logic [7:0]  RST_SCALE   = 8'd60;

    localparam logic [16:0] SINCE_MAX = 17'h1FFFF;

    typedef struct packed {
        logic start_req;
        logic edge_req;
    } t_in_word;

    typedef struct packed {
        logic [15:0] live_rpm;
        logic [15:0] final_rpm;
        logic [7:0]  gates_left;
        logic        finished;
    } t_out_word;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_SUM,
        ST_FIN,
        ST_DIV,
        ST_OUT
    } t_state;

endpackage

// ----- design/gated_rpm_tachometer.sv -----
// ----------------------------------------------------------------------------
// gated_rpm_tachometer
// Gated pulse-count tachometer with debounce lockout and windowed average.
// ----------------------------------------------------------------------------
//  channel | direction | handshake                  | word
//  in      | input     | i_in_valid / o_in_stall    | i_in_word  (grt_pkg::t_in_word)
//  out     | output    | o_out_valid / i_out_stall  | o_out_word (grt_pkg::t_out_word)
//  cfg     | input     | i_cfg_we                   | i_cfg_idx, i_cfg_data
//
//  A tick that ends no gate is taken in the idle state. A tick that ends a
//  gate passes through multiply, sum, check and output load; the last gate of
//  a test with a non-empty window also runs the bit-serial divide of the window sum.
//  Reset is synchronous; no clearing pass is needed.
//  A full output register holds the next gate result back until taken.
// ----------------------------------------------------------------------------
module gated_rpm_tachometer (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  grt_pkg::t_in_word               i_in_word,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output grt_pkg::t_out_word              o_out_word,
    input  logic                            i_cfg_we,
    input  logic [grt_pkg::CfgIdxW-1:0]     i_cfg_idx,
    input  logic [grt_pkg::CfgDataW-1:0]    i_cfg_data
);

    grt_pkg::t_state r_state, n_state;

    logic [15:0] r_lockout;
    logic [23:0] r_gate;
    logic [7:0]  r_wfirst, r_wlast, r_tgates, r_scale;

    logic        r_running, n_running;
    logic        r_done, n_done;
    logic [23:0] r_gcnt, n_gcnt;
    logic [16:0] r_since, n_since;
    logic [15:0] r_ecnt, n_ecnt;
    logic [7:0]  r_gel, n_gel;
    logic [31:0] r_sum, n_sum;
    logic [7:0]  r_scnt, n_scnt;
    logic [15:0] r_snap, n_snap;
    logic [15:0] r_live, n_live;
    logic [31:0] r_quo, n_quo;
    logic [7:0]  r_rem, n_rem;
    logic [4:0]  r_dcnt, n_dcnt;
    logic        r_out_valid, n_out_valid;
    grt_pkg::t_out_word r_out, n_out;

    logic        in_acc, out_acc;
    logic [16:0] elapsed;
    logic [23:0] gcnt_inc;
    logic [23:0] prod;
    logic [8:0]  rem_sh;

    assign in_acc      = i_in_valid && !o_in_stall;
    assign out_acc     = r_out_valid && !i_out_stall;
    assign o_in_stall  = (r_state != grt_pkg::ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out;

    assign elapsed  = (r_since < grt_pkg::SINCE_MAX) ? r_since + 17'd1 : grt_pkg::SINCE_MAX;
    assign gcnt_inc = r_gcnt + 24'd1;
    assign prod     = {8'd0, r_snap} * {16'd0, r_scale};
    assign rem_sh   = {r_rem, r_quo[31]};

    always_comb begin
        n_state     = r_state;
        n_running   = r_running;
        n_done      = r_done;
        n_gcnt      = r_gcnt;
        n_since     = r_since;
        n_ecnt      = r_ecnt;
        n_gel       = r_gel;
        n_sum       = r_sum;
        n_scnt      = r_scnt;
        n_snap      = r_snap;
        n_live      = r_live;
        n_quo       = r_quo;
        n_rem       = r_rem;
        n_dcnt      = r_dcnt;
        n_out_valid = out_acc ? 1'b0 : r_out_valid;
        n_out       = r_out;
        case (r_state)
            grt_pkg::ST_IDLE: begin
                if (in_acc) begin
                    if (i_in_word.start_req) begin
                        n_running = 1'b1;
                        n_done    = 1'b0;
                        n_gcnt    = '0;
                        n_since   = grt_pkg::SINCE_MAX;
                        n_ecnt    = '0;
                        n_gel     = '0;
                        n_sum     = '0;
                        n_scnt    = '0;
                        n_quo     = '0;
                    end else if (r_running && !r_done) begin
                        n_snap = r_ecnt;
                        if (i_in_word.edge_req && (elapsed > {1'b0, r_lockout})) begin
                            n_since = '0;
                            if (r_ecnt != 16'hFFFF) begin
                                n_snap = r_ecnt + 16'd1;
                            end
                        end else begin
                            n_since = elapsed;
                        end
                        n_ecnt = n_snap;
                        n_gcnt = gcnt_inc;
                        if (gcnt_inc == 24'd0 || gcnt_inc >= r_gate) begin
                            n_gcnt = '0;
                            n_ecnt = '0;
                            if (r_gel != 8'hFF) begin
                                n_gel = r_gel + 8'd1;
                            end
                            n_state = grt_pkg::ST_MUL;
                        end
                    end
                end
            end
            grt_pkg::ST_MUL: begin
                n_live  = (prod > 24'h00FFFF) ? 16'hFFFF : prod[15:0];
                n_state = grt_pkg::ST_SUM;
            end
            grt_pkg::ST_SUM: begin
                if (r_gel >= r_wfirst && r_gel <= r_wlast) begin
                    n_sum = r_sum + {16'd0, r_live};
                    if (r_scnt != 8'hFF) begin
                        n_scnt = r_scnt + 8'd1;
                    end
                end
                n_state = grt_pkg::ST_FIN;
            end
            grt_pkg::ST_FIN: begin
                n_state = grt_pkg::ST_OUT;
                if (r_gel >= r_tgates) begin
                    n_done    = 1'b1;
                    n_running = 1'b0;
                    n_quo     = '0;
                    if (r_scnt != 8'd0) begin
                        n_quo   = r_sum;
                        n_rem   = '0;
                        n_dcnt  = '0;
                        n_state = grt_pkg::ST_DIV;
                    end
                end
            end
            grt_pkg::ST_DIV: begin
                // restoring divide, one quotient bit a cycle
                if (rem_sh >= {1'b0, r_scnt}) begin
                    n_rem = 8'(rem_sh - {1'b0, r_scnt});
                    n_quo = {r_quo[30:0], 1'b1};
                end else begin
                    n_rem = rem_sh[7:0];
                    n_quo = {r_quo[30:0], 1'b0};
                end
                n_dcnt = r_dcnt + 5'd1;
                if (r_dcnt == 5'd31) begin
                    n_state = grt_pkg::ST_OUT;
                end
            end
            grt_pkg::ST_OUT: begin
                if (!r_out_valid || out_acc) begin
                    n_out.live_rpm   = r_live;
                    n_out.final_rpm  = r_done ? r_quo[15:0] : 16'd0;
                    n_out.gates_left = (r_gel < r_tgates) ? r_tgates - r_gel : 8'd0;
                    n_out.finished   = r_done;
                    n_out_valid      = 1'b1;
                    n_state          = grt_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = grt_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= grt_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lockout <= grt_pkg::RST_LOCKOUT;
            r_gate    <= grt_pkg::RST_GATE;
            r_wfirst  <= grt_pkg::RST_WFIRST;
            r_wlast   <= grt_pkg::RST_WLAST;
            r_tgates  <= grt_pkg::RST_TGATES;
            r_scale   <= grt_pkg::RST_SCALE;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                grt_pkg::REG_LOCKOUT: r_lockout <= i_cfg_data[15:0];
                grt_pkg::REG_GATE:    r_gate    <= i_cfg_data;
                grt_pkg::REG_WFIRST:  r_wfirst  <= i_cfg_data[7:0];
                grt_pkg::REG_WLAST:   r_wlast   <= i_cfg_data[7:0];
                grt_pkg::REG_TGATES:  r_tgates  <= i_cfg_data[7:0];
                grt_pkg::REG_SCALE:   r_scale   <= i_cfg_data[7:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_running   <= 1'b0;
            r_done      <= 1'b0;
            r_gcnt      <= '0;
            r_since     <= grt_pkg::SINCE_MAX;
            r_ecnt      <= '0;
            r_gel       <= '0;
            r_sum       <= '0;
            r_scnt      <= '0;
            r_dcnt      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_running   <= n_running;
            r_done      <= n_done;
            r_gcnt      <= n_gcnt;
            r_since     <= n_since;
            r_ecnt      <= n_ecnt;
            r_gel       <= n_gel;
            r_sum       <= n_sum;
            r_scnt      <= n_scnt;
            r_dcnt      <= n_dcnt;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_snap <= n_snap;
        r_live <= n_live;
        r_quo  <= n_quo;
        r_rem  <= n_rem;
        r_out  <= n_out;
    end

endmodule

// ----- tb/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the gated RPM tachometer. Feeds time-base ticks with
// start and sensor-edge flags under random input gaps and output stalls, and
// compares every gate result against a cycle-free prediction of the counter.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int ITEMS = 450;

    class tacho_scoreboard;
        logic [15:0] lockout;
        logic [23:0] gate_len;
        logic [7:0]  win_first;
        logic [7:0]  win_last;
        logic [7:0]  test_len;
        logic [7:0]  scale;

        bit          running;
        bit          done;
        logic [23:0] gate_cnt;
        logic [16:0] since;
        logic [15:0] edges;
        logic [7:0]  gates_done;
        logic [31:0] rpm_sum;
        logic [7:0]  sum_n;
        logic [15:0] final_val;

        grt_pkg::t_out_word gate_results_due[$];
        int          errors;
        int          results_seen;

        function new();
            lockout   = grt_pkg::RST_LOCKOUT;
            gate_len  = grt_pkg::RST_GATE;
            win_first = grt_pkg::RST_WFIRST;
            win_last  = grt_pkg::RST_WLAST;
            test_len  = grt_pkg::RST_TGATES;
            scale     = grt_pkg::RST_SCALE;
            clear_test();
            errors       = 0;
            results_seen = 0;
        endfunction

        function void clear_test();
            running    = 1'b0;
            done       = 1'b0;
            gate_cnt   = '0;
            since      = grt_pkg::SINCE_MAX;
            edges      = '0;
            gates_done = '0;
            rpm_sum    = '0;
            sum_n      = '0;
            final_val  = '0;
        endfunction

        function void write_reg(logic [grt_pkg::CfgIdxW-1:0] idx,
                                logic [grt_pkg::CfgDataW-1:0] data);
            case (idx)
                grt_pkg::REG_LOCKOUT: lockout   = data[15:0];
                grt_pkg::REG_GATE:    gate_len  = data[23:0];
                grt_pkg::REG_WFIRST:  win_first = data[7:0];
                grt_pkg::REG_WLAST:   win_last  = data[7:0];
                grt_pkg::REG_TGATES:  test_len  = data[7:0];
                grt_pkg::REG_SCALE:   scale     = data[7:0];
                default: ;
            endcase
        endfunction

        // returns 1 when the tick was taken by a running test
        function bit feed_tick(grt_pkg::t_in_word w);
            logic [16:0] elapsed;
            logic [31:0] live;
            grt_pkg::t_out_word r;
            if (w.start_req) begin
                clear_test();
                running = 1'b1;
                return 1'b0;
            end
            if (!running || done) return 1'b0;

            elapsed = (since < grt_pkg::SINCE_MAX) ? since + 17'd1 : grt_pkg::SINCE_MAX;
            if (w.edge_req && elapsed > {1'b0, lockout}) begin
                if (edges != 16'hFFFF) edges = edges + 16'd1;
                since = '0;
            end else begin
                since = elapsed;
            end

            gate_cnt = gate_cnt + 24'd1;
            if (gate_cnt != 0 && gate_cnt < gate_len) return 1'b1;
            gate_cnt = '0;

            if (gates_done != 8'hFF) gates_done = gates_done + 8'd1;
            live = 32'(edges) * 32'(scale);
            if (live > 32'hFFFF) live = 32'hFFFF;
            edges = '0;

            if (gates_done >= win_first && gates_done <= win_last) begin
                rpm_sum = rpm_sum + live;
                if (sum_n != 8'hFF) sum_n = sum_n + 8'd1;
            end

            if (gates_done >= test_len) begin
                done      = 1'b1;
                running   = 1'b0;
                final_val = (sum_n != 0) ? 16'(rpm_sum / 32'(sum_n)) : 16'd0;
            end

            r.live_rpm   = live[15:0];
            r.final_rpm  = done ? final_val : 16'd0;
            r.gates_left = (gates_done < test_len) ? test_len - gates_done : 8'd0;
            r.finished   = done;
            gate_results_due.push_back(r);
            return 1'b1;
        endfunction

        task report_mismatch(string msg);
            $display("mismatch at %0t: %s", $realtime, msg);
            errors++;
        endtask

        task compare_field(string name, int unsigned got, int unsigned want);
            if (got != want)
                report_mismatch($sformatf("%s got %0d want %0d", name, got, want));
        endtask

        task take_gate_result(grt_pkg::t_out_word got);
            grt_pkg::t_out_word want;
            results_seen++;
            if (gate_results_due.size() == 0) begin
                report_mismatch($sformatf("unexpected gate result %h", got));
                return;
            end
            want = gate_results_due.pop_front();
            compare_field("live_rpm",   got.live_rpm,   want.live_rpm);
            compare_field("final_rpm",  got.final_rpm,  want.final_rpm);
            compare_field("gates_left", got.gates_left, want.gates_left);
            compare_field("finished",   got.finished,   want.finished);
        endtask
    endclass

    logic                         clk       = 1'b0;
    logic                         rst_n     = 1'b0;
    logic                         in_valid  = 1'b0;
    logic                         in_stall;
    grt_pkg::t_in_word            in_word   = '0;
    logic                         out_valid;
    logic                         out_stall = 1'b0;
    grt_pkg::t_out_word           out_word;
    logic                         cfg_we    = 1'b0;
    logic [grt_pkg::CfgIdxW-1:0]  cfg_idx   = '0;
    logic [grt_pkg::CfgDataW-1:0] cfg_data  = '0;

    tacho_scoreboard sb = new();
    bit calm       = 1'b0;
    int stall_run  = 0;
    int fed        = 0;
    int sent       = 0;
    int cfg_sets   = 0;

    gated_rpm_tachometer dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_word   (in_word),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_word  (out_word),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_data  (cfg_data)
    );

    always begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    always @(posedge clk) begin
        if (!rst_n || calm) begin
            out_stall <= 1'b0;
            stall_run = 0;
        end else if (stall_run > 0) begin
            out_stall <= 1'b1;
            stall_run--;
        end else begin
            out_stall <= 1'b0;
            if ($urandom_range(0, 3) == 0) stall_run = idle_len();
        end
    end

    always @(posedge clk) begin
        if (rst_n && out_valid && !out_stall) sb.take_gate_result(out_word);
    end

    // returns at the accepting edge with valid still high
    task automatic send_word(grt_pkg::t_in_word w);
        int gap;
        gap = idle_len();
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_word  <= w;
        do @(posedge clk); while (in_stall);
        sent++;
        if (sb.feed_tick(w)) fed++;
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        while (sb.gate_results_due.size() != 0) @(posedge clk);
        repeat (50) @(posedge clk);
    endtask

    task automatic set_reg(logic [grt_pkg::CfgIdxW-1:0] idx,
                           logic [grt_pkg::CfgDataW-1:0] data);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= data;
        @(posedge clk);
        sb.write_reg(idx, data);
    endtask

    task automatic set_one(logic [grt_pkg::CfgIdxW-1:0] idx,
                           logic [grt_pkg::CfgDataW-1:0] data);
        set_reg(idx, data);
        cfg_we <= 1'b0;
    endtask

    // narrow registers get random junk above their width
    task automatic apply_cfg(logic [15:0] lo, logic [23:0] gt, logic [7:0] wf,
                             logic [7:0] wl, logic [7:0] tg, logic [7:0] sc);
        set_reg(grt_pkg::REG_LOCKOUT, {8'($urandom), lo});
        set_reg(grt_pkg::REG_GATE,    gt);
        set_reg(grt_pkg::REG_WFIRST,  {16'($urandom), wf});
        set_reg(grt_pkg::REG_WLAST,   {16'($urandom), wl});
        set_reg(grt_pkg::REG_TGATES,  {16'($urandom), tg});
        set_reg(grt_pkg::REG_SCALE,   {16'($urandom), sc});
        cfg_we <= 1'b0;
        cfg_sets++;
    endtask

    task automatic run_random_test();
        logic [15:0] lo;
        logic [23:0] gt;
        logic [7:0]  wf, wl, tg, sc;
        int          ticks, density, pick;
        grt_pkg::t_in_word w;
        pick = $urandom_range(0, 9);
        lo = (pick == 0) ? 16'hFFFF : (pick == 1) ? 16'($urandom)
                                                  : 16'($urandom_range(0, 6));
        pick = $urandom_range(0, 19);
        gt = (pick == 0) ? 24'd0 : (pick == 1) ? 24'hFFFFFF
           : (pick == 2) ? 24'($urandom) : 24'($urandom_range(1, 12));
        wf = ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'($urandom_range(0, 5));
        wl = ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'($urandom_range(0, 8));
        tg = ($urandom_range(0, 14) == 0) ? 8'hFF : 8'($urandom_range(0, 6));
        sc = 8'($urandom);
        case ($urandom_range(0, 3))
            0:       density = 10;
            1:       density = 35;
            2:       density = 70;
            default: density = 100;
        endcase
        calm = ($urandom_range(0, 4) == 0);
        apply_cfg(lo, gt, wf, wl, tg, sc);

        repeat ($urandom_range(0, 2)) send_word({1'b0, 1'($urandom)});
        send_word({1'b1, 1'($urandom)});
        if (gt > 24'd300) ticks = 301;
        else ticks = ((tg == 0) ? 1 : int'(tg)) * ((gt == 0) ? 1 : int'(gt));
        ticks += $urandom_range(0, 4);
        if (ticks > 300) ticks = $urandom_range(40, 300);
        if (ticks > ITEMS - sent) ticks = (ITEMS - sent < 1) ? 1 : ITEMS - sent;

        for (int i = 0; i < ticks; i++) begin
            if (i == ticks / 2 && $urandom_range(0, 4) == 0) begin
                settle();
                if ($urandom_range(0, 1))
                    set_one(grt_pkg::REG_GATE, 24'($urandom_range(0, 12)));
                else
                    set_one(grt_pkg::REG_LOCKOUT, 24'($urandom_range(0, 8)));
            end
            w.start_req = ($urandom_range(0, 99) == 0);
            w.edge_req  = ($urandom_range(1, 100) <= density);
            send_word(w);
        end
        settle();
    endtask

    initial begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // ticks with no test running
        send_word(2'b01);
        send_word(2'b00);
        settle();

        // full window, max scale, tick after finish ignored
        apply_cfg(16'd0, 24'd3, 8'd1, 8'd255, 8'd2, 8'd255);
        send_word(2'b11);
        repeat (7) send_word(2'b01);
        settle();

        // zero gate length, empty window, zero test length, max lockout
        apply_cfg(16'hFFFF, 24'd0, 8'd5, 8'd4, 8'd0, 8'd1);
        send_word(2'b10);
        send_word(2'b01);
        send_word(2'b01);
        settle();

        // lockout rejection, gate shortened mid-gate, restart mid-test
        apply_cfg(16'd1, 24'd4, 8'd2, 8'd2, 8'd255, 8'd60);
        send_word(2'b11);
        repeat (6) send_word(2'b01);
        settle();
        set_one(grt_pkg::REG_GATE, 24'd2);
        repeat (2) send_word(2'b01);
        send_word(2'b10);
        send_word(2'b01);
        settle();

        while (sent < ITEMS)
            run_random_test();

        settle();
        $display("summary: %0d words sent, %0d ticks fed to running tests, %0d gate results checked",
                 sent, fed, sb.results_seen);
        $display("summary: %0d register settings incl. zero gate, empty window, restarts",
                 cfg_sets);
        if (sb.errors == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    initial begin
        #100_000_000;
        $display("timeout with %0d gate results outstanding", sb.gate_results_due.size());
        $display("tb: failure");
        $finish;
    end

endmodule

// ----- files.f -----
design/grt_pkg.sv
design/gated_rpm_tachometer.sv
tb/tb_top.sv
